### design/lz_match_token_encoder_macros.svh
// Assertion macros for the match token encoder modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef LZ_MATCH_TOKEN_ENCODER_MACROS_SVH
`define LZ_MATCH_TOKEN_ENCODER_MACROS_SVH

// same-cycle implication, off during reset
`define LZME_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LZME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lzme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the match token encoder.
// No dependencies.
package lzme_pkg;

   localparam int MAX_MATCH_LEN = 8191;

   localparam int IMG_W     = 24;
   localparam int PIX_W     = 25;
   localparam int LEN_W     = 13;
   localparam int LEN_SAT_W = LEN_W + 1;
   localparam int BYTE_W    = 8;

   localparam int PIX_SHORT_LIMIT  = 4096;
   localparam int PIX_MEDIUM_LIMIT = 131072;
   localparam int SHORT_IMG_L1     = 64;
   localparam int SHORT_IMG_L2     = 16384;
   localparam int SHORT_IMG_L3     = 4194304;
   localparam int FAR_IMG_L1       = 256;
   localparam int FAR_IMG_L2       = 65536;
   localparam int RUN_BYTE         = 255;
   localparam int LEN_FIELD_MAX    = 7;

   localparam int TAIL_MAX   = 5;
   localparam int TAIL_IDX_W = $clog2(TAIL_MAX);
   localparam int TAIL_CNT_W = $clog2(TAIL_MAX + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0]                first_byte;
      logic                             len_ext;
      logic [LEN_W-1:0]                 rest;
      logic [BYTE_W-1:0]                pix_byte;
      logic [TAIL_MAX-1:0][BYTE_W-1:0]  tail;
      logic [TAIL_CNT_W-1:0]            tail_cnt;
   } token_type;

   typedef enum logic [1:0] {
      ST_FIRST,
      ST_RUN,
      ST_PIX,
      ST_TAIL
   } back_state_type;

endpackage

### design/lzme_front.sv
`timescale 1ns / 1ps
// Front end: accepts a match reference and classifies it into a token
// descriptor for the queue. Depends on lzme_pkg.
module lzme_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lzme_pkg::IMG_W-1:0]    req_image_dist,
   input  logic [lzme_pkg::PIX_W-1:0]    req_pixel_dist,
   input  logic [lzme_pkg::LEN_W-1:0]    req_match_len,
   input  logic                          queue_full,
   output logic                          push,
   output lzme_pkg::token_type           token
);

   logic [lzme_pkg::LEN_W-1:0]                           len;
   logic                                                 is_short;
   logic                                                 is_long;
   logic                                                 far_flag;
   logic [1:0]                                           sel;
   logic [lzme_pkg::TAIL_MAX-1:0][lzme_pkg::BYTE_W-1:0]  base;
   logic [lzme_pkg::TAIL_CNT_W-1:0]                      base_cnt;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      if ({1'b0, req_match_len} > lzme_pkg::LEN_SAT_W'(lzme_pkg::MAX_MATCH_LEN)) begin
         len = lzme_pkg::LEN_W'(lzme_pkg::MAX_MATCH_LEN);
      end else begin
         len = req_match_len;
      end
   end

   assign is_short = req_pixel_dist < lzme_pkg::PIX_W'(lzme_pkg::PIX_SHORT_LIMIT);
   assign is_long  = req_pixel_dist >= lzme_pkg::PIX_W'(lzme_pkg::PIX_MEDIUM_LIMIT);
   assign far_flag = !is_short;

   always_comb begin
      if (is_short) begin
         priority if (req_image_dist < lzme_pkg::IMG_W'(lzme_pkg::SHORT_IMG_L1)) sel = 2'd0;
         else if (req_image_dist < lzme_pkg::IMG_W'(lzme_pkg::SHORT_IMG_L2)) sel = 2'd1;
         else if (req_image_dist < lzme_pkg::IMG_W'(lzme_pkg::SHORT_IMG_L3)) sel = 2'd2;
         else sel = 2'd3;
         base[0] = {sel, req_image_dist[5:0]};
         base[1] = req_image_dist[13:6];
         base[2] = req_image_dist[21:14];
         base[3] = {6'd0, req_image_dist[23:22]};
         base[4] = '0;
      end else begin
         priority if (req_image_dist == '0) sel = 2'd0;
         else if (req_image_dist < lzme_pkg::IMG_W'(lzme_pkg::FAR_IMG_L1)) sel = 2'd1;
         else if (req_image_dist < lzme_pkg::IMG_W'(lzme_pkg::FAR_IMG_L2)) sel = 2'd2;
         else sel = 2'd3;
         base[0] = {sel, is_long, req_pixel_dist[16:12]};
         base[1] = req_image_dist[7:0];
         base[2] = req_image_dist[15:8];
         base[3] = req_image_dist[23:16];
         base[4] = '0;
      end
      base_cnt = lzme_pkg::TAIL_CNT_W'(sel) + lzme_pkg::TAIL_CNT_W'(1);
   end

   always_comb begin
      if (len < lzme_pkg::LEN_W'(lzme_pkg::LEN_FIELD_MAX)) begin
         token.first_byte = {len[2:0], far_flag, req_pixel_dist[3:0]};
         token.len_ext    = 1'b0;
         token.rest       = '0;
      end else begin
         token.first_byte = {3'(lzme_pkg::LEN_FIELD_MAX), far_flag, req_pixel_dist[3:0]};
         token.len_ext    = 1'b1;
         token.rest       = len - lzme_pkg::LEN_W'(lzme_pkg::LEN_FIELD_MAX);
      end
      token.pix_byte = req_pixel_dist[11:4];
      // a long far reference appends pixel bits 17..24 after the image bytes
      for (int i = 0; i < lzme_pkg::TAIL_MAX; i++) begin
         if (far_flag && is_long && (lzme_pkg::TAIL_CNT_W'(i) == base_cnt)) begin
            token.tail[i] = req_pixel_dist[24:17];
         end else begin
            token.tail[i] = base[i];
         end
      end
      token.tail_cnt = (far_flag && is_long) ? base_cnt + lzme_pkg::TAIL_CNT_W'(1) : base_cnt;
   end

endmodule

### design/lzme_queue.sv
`timescale 1ns / 1ps
// Short token queue between the front end and the byte sequencer.
// Depends on lzme_pkg.
module lzme_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lzme_pkg::token_type  push_token,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output lzme_pkg::token_type  head
);

   lzme_pkg::token_type                 mem_ff [lzme_pkg::QUEUE_DEPTH];
   logic [lzme_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lzme_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lzme_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign full       = count_ff == lzme_pkg::QUEUE_CNT_W'(lzme_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lzme_pkg::QUEUE_PTR_W'(lzme_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lzme_pkg::QUEUE_PTR_W'(lzme_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/lzme_back.sv
`timescale 1ns / 1ps
// Back end: walks the head token byte by byte into the output register.
// Depends on lzme_pkg and lz_match_token_encoder_macros.svh.
`include "lz_match_token_encoder_macros.svh"

module lzme_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  lzme_pkg::token_type            head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lzme_pkg::BYTE_W-1:0]    rsp_code_byte,
   output logic                           rsp_last_byte
);

   lzme_pkg::back_state_type            state_ff, state_in;
   logic [lzme_pkg::LEN_W-1:0]          rest_ff, rest_in;
   logic [lzme_pkg::TAIL_IDX_W-1:0]     idx_ff, idx_in;
   logic                                rsp_valid_ff;
   logic [lzme_pkg::BYTE_W-1:0]         rsp_code_byte_ff;
   logic                                rsp_last_byte_ff;
   logic                                emit_ok;
   logic [lzme_pkg::BYTE_W-1:0]         emit_byte;
   logic                                emit_last;

   assign emit_ok       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_byte = rsp_code_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   always_comb begin
      state_in  = state_ff;
      rest_in   = rest_ff;
      idx_in    = idx_ff;
      emit_byte = '0;
      emit_last = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         lzme_pkg::ST_FIRST: begin
            emit_byte = head.first_byte;
            if (emit_ok) begin
               rest_in  = head.rest;
               idx_in   = '0;
               state_in = head.len_ext ? lzme_pkg::ST_RUN : lzme_pkg::ST_PIX;
            end
         end
         lzme_pkg::ST_RUN: begin
            if (rest_ff >= lzme_pkg::LEN_W'(lzme_pkg::RUN_BYTE)) begin
               emit_byte = lzme_pkg::BYTE_W'(lzme_pkg::RUN_BYTE);
               if (emit_ok) begin
                  rest_in = rest_ff - lzme_pkg::LEN_W'(lzme_pkg::RUN_BYTE);
               end
            end else begin
               emit_byte = rest_ff[lzme_pkg::BYTE_W-1:0];
               if (emit_ok) begin
                  state_in = lzme_pkg::ST_PIX;
               end
            end
         end
         lzme_pkg::ST_PIX: begin
            emit_byte = head.pix_byte;
            if (emit_ok) begin
               state_in = lzme_pkg::ST_TAIL;
            end
         end
         lzme_pkg::ST_TAIL: begin
            emit_byte = head.tail[idx_ff];
            emit_last = lzme_pkg::TAIL_CNT_W'(idx_ff) + lzme_pkg::TAIL_CNT_W'(1)
                        == head.tail_cnt;
            if (emit_ok) begin
               if (emit_last) begin
                  pop      = 1'b1;
                  state_in = lzme_pkg::ST_FIRST;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = lzme_pkg::ST_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzme_pkg::ST_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      idx_ff  <= idx_in;
      if (emit_ok) begin
         rsp_code_byte_ff <= emit_byte;
         rsp_last_byte_ff <= emit_last;
      end
   end

   `LZME_ASSERT_NOW(a_busy_has_token, state_ff != lzme_pkg::ST_FIRST, head_valid,
      "sequencer mid-token with empty queue")
   `LZME_ASSERT_NOW(a_pop_on_last, pop, emit_ok && emit_last,
      "token popped before its last beat")
   `LZME_ASSERT_NOW(a_tail_idx_range, state_ff == lzme_pkg::ST_TAIL,
      lzme_pkg::TAIL_CNT_W'(idx_ff) < head.tail_cnt, "tail index past tail count")
   `LZME_ASSERT_NEXT(a_last_ends_token, emit_ok && emit_last,
      state_ff == lzme_pkg::ST_FIRST && rsp_valid_ff && rsp_last_byte_ff,
      "last beat did not return sequencer to first byte")

endmodule

### design/lz_match_token_encoder.sv
`timescale 1ns / 1ps
// Top level of the LZ match token encoder.
// Depends on lzme_pkg, lzme_front, lzme_queue and lzme_back.
//
// Usage:
//   req_*  : one match reference per beat (image distance, biased pixel
//            distance, biased length), valid/ready.
//   rsp_*  : the reference's code, one byte per beat; rsp_last_byte marks
//            the final byte of each reference.
//   A reference is classified in the cycle it is accepted and parked in a
//   two-entry token queue. The byte sequencer drains the queue head into an
//   output register, one byte per cycle while rsp_ready does not stall it.
// Path: request -> queue entry -> output register for the first byte.
// Throughput: one output byte per cycle while rsp_ready does not stall it;
//   a reference is 3 to 40 bytes with the default length bound, and its
//   length run of 255 bytes is counted down one byte per cycle.
// Reset: empties the queue and the output register, sequencer goes to the
//   first byte; references still held in the queue are dropped.
// Stall: when rsp_ready is low the output byte holds; the queue keeps
//   accepting references until both entries are filled.
module lz_match_token_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lzme_pkg::IMG_W-1:0]     req_image_dist,
   input  logic [lzme_pkg::PIX_W-1:0]     req_pixel_dist,
   input  logic [lzme_pkg::LEN_W-1:0]     req_match_len,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lzme_pkg::BYTE_W-1:0]    rsp_code_byte,
   output logic                           rsp_last_byte
);

   lzme_pkg::token_type  push_token;
   lzme_pkg::token_type  head;
   logic                 push;
   logic                 full;
   logic                 pop;
   logic                 head_valid;

   lzme_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_image_dist (req_image_dist),
      .req_pixel_dist (req_pixel_dist),
      .req_match_len  (req_match_len),
      .queue_full     (full),
      .push           (push),
      .token          (push_token)
   );

   lzme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   lzme_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
